FILE: src/dcfr_pkg.sv
// ----------------------------------------------------------------------------
// dcfr_pkg: shared definitions for the drip counter
// Operation codes, register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
package dcfr_pkg;

	// operation codes carried in tuser
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_WINDOW   = 2'd1;
	localparam logic [1:0] REG_TIMEOUT  = 2'd2;

	// register reset values
	localparam logic [15:0] DEBOUNCE_RST = 16'd200;
	localparam logic [31:0] WINDOW_RST   = 32'd60000;
	localparam logic [31:0] TIMEOUT_RST  = 32'd10000;

	// widths of counters, quotient and the rate numerator
	localparam int CNT_W   = 32;
	localparam int QUOT_W  = 32;
	localparam int SCALE_W = 24;
	localparam int NUM_W   = CNT_W + SCALE_W;

	// ms per minute times one in Q24.8
	localparam logic [SCALE_W-1:0] RATE_SCALE = 24'd15360000;

endpackage

FILE: src/dcfr_div.sv
// ----------------------------------------------------------------------------
// dcfr_div: iterative rate divider
// One subtract and compare unit, reused for the overflow check and then for
// one quotient bit per cycle (restoring division, saturating quotient).
// ----------------------------------------------------------------------------
module dcfr_div
	import dcfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  dividend,
	input  logic [QUOT_W-1:0] divisor,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	localparam logic [1:0] D_IDLE  = 2'd0;
	localparam logic [1:0] D_CHECK = 2'd1;
	localparam logic [1:0] D_STEP  = 2'd2;

	localparam int BIT_W = $clog2(QUOT_W);

	logic [1:0]        state_q;
	logic [BIT_W-1:0]  cnt_q;
	logic              done_q;
	logic [QUOT_W-1:0] rem_q;
	logic [QUOT_W-1:0] low_q;
	logic [QUOT_W-1:0] quot_q;
	logic [QUOT_W-1:0] dvs_q;

	logic [QUOT_W:0]   opa;
	logic [QUOT_W+1:0] diff;
	logic              ge;

	// shared unit: compare the high part on check, shifted remainder on steps
	always_comb begin
		opa  = (state_q == D_CHECK) ? {1'b0, rem_q} : {rem_q, low_q[QUOT_W-1]};
		diff = {1'b0, opa} - {2'b00, dvs_q};
		ge   = !diff[QUOT_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_CHECK;
					end
				end
				D_CHECK: begin
					if (ge) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						cnt_q   <= '0;
						state_q <= D_STEP;
					end
				end
				D_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == BIT_W'(QUOT_W - 1)) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				if (start) begin
					rem_q <= QUOT_W'(dividend[NUM_W-1:QUOT_W]);
					low_q <= dividend[QUOT_W-1:0];
					dvs_q <= divisor;
				end
			end
			D_CHECK: begin
				// high part not below divisor: quotient overflows
				if (ge) begin
					quot_q <= '1;
				end
			end
			D_STEP: begin
				rem_q  <= ge ? diff[QUOT_W-1:0] : opa[QUOT_W-1:0];
				low_q  <= {low_q[QUOT_W-2:0], 1'b0};
				quot_q <= {quot_q[QUOT_W-2:0], ge};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

FILE: src/drip_counter_with_flow_rate.sv
// ----------------------------------------------------------------------------
// drip_counter_with_flow_rate: debounced drip counter with flow-rate meter
// Counts debounced sensor edges on millisecond ticks and answers flow
// queries in drops per minute, unsigned Q24.8.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: sensor_level, tuser: op
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: event, total, no_drip, rate
//  cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
//  tick, clear and unused op: result registered the next cycle.
//  flow query: product registered, divider start, overflow check (saturates on
//  overflow), then 32 steps at one quotient bit a cycle; zero window answers at once.
//  input is taken only when idle and the result register is free or draining.
//  asynchronous active-low reset; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
module drip_counter_with_flow_rate
	import dcfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [0] sensor_level, [7:1] zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // [0] drip_event, [32:1] drip_total,
	                                   // [33] no_drip, [65:34] flow_rate, [71:66] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;

	logic [1:0]        state_q;
	logic [15:0]       debounce_q;
	logic [CNT_W-1:0]  window_len_q;
	logic [CNT_W-1:0]  timeout_q;
	logic              last_level_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  win_drips_q;
	logic [CNT_W-1:0]  since_q;
	logic [CNT_W-1:0]  win_ms_q;

	logic              out_vld_q;
	logic              out_event_q;
	logic [CNT_W-1:0]  out_total_q;
	logic              out_nodrip_q;
	logic [QUOT_W-1:0] out_rate_q;

	logic [NUM_W-1:0]  product_s1;
	logic [CNT_W-1:0]  divisor_q;

	logic              accept;
	logic              drip;
	logic              query_go;
	logic              event_d;
	logic              last_d;
	logic              nodrip_d;
	logic [CNT_W-1:0]  since_inc;
	logic [CNT_W-1:0]  winms_inc;
	logic [CNT_W-1:0]  total_d;
	logic [CNT_W-1:0]  win_drips_d;
	logic [CNT_W-1:0]  since_d;
	logic [CNT_W-1:0]  win_ms_d;

	logic              div_start;
	logic              div_done;
	logic [QUOT_W-1:0] div_quot;

	assign s_axis_tready = (state_q == ST_IDLE) && (!out_vld_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign div_start     = (state_q == ST_START);
	assign cfg_ready     = 1'b1;

	always_comb begin
		since_inc   = (since_q == '1) ? since_q : since_q + 1'b1;
		winms_inc   = (win_ms_q == '1) ? win_ms_q : win_ms_q + 1'b1;
		// falling edge counts only once the debounce time has passed
		drip        = last_level_q && !s_axis_tdata[0] &&
		              (since_inc >= CNT_W'(debounce_q));
		last_d      = last_level_q;
		total_d     = total_q;
		win_drips_d = win_drips_q;
		since_d     = since_q;
		win_ms_d    = win_ms_q;
		event_d     = 1'b0;
		query_go    = 1'b0;
		if (accept) begin
			unique case (s_axis_tuser)
				OP_TICK: begin
					last_d   = s_axis_tdata[0];
					win_ms_d = winms_inc;
					since_d  = drip ? '0 : since_inc;
					event_d  = drip;
					if (drip) begin
						total_d     = total_q + 1'b1;
						win_drips_d = win_drips_q + 1'b1;
					end
				end
				OP_QUERY: begin
					// empty window answers zero and keeps the window
					if (win_ms_q != '0) begin
						query_go = 1'b1;
						if (win_ms_q >= window_len_q) begin
							win_ms_d    = '0;
							win_drips_d = '0;
						end
					end
				end
				OP_CLEAR: begin
					total_d     = '0;
					win_drips_d = '0;
					since_d     = '0;
					win_ms_d    = '0;
				end
				default: ;
			endcase
		end
		nodrip_d = (since_d >= timeout_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			debounce_q   <= DEBOUNCE_RST;
			window_len_q <= WINDOW_RST;
			timeout_q    <= TIMEOUT_RST;
			last_level_q <= 1'b1;
			total_q      <= '0;
			win_drips_q  <= '0;
			since_q      <= '0;
			win_ms_q     <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			last_level_q <= last_d;
			total_q      <= total_d;
			win_drips_q  <= win_drips_d;
			since_q      <= since_d;
			win_ms_q     <= win_ms_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_DEBOUNCE: debounce_q   <= cfg_data[15:0];
					REG_WINDOW:   window_len_q <= cfg_data;
					REG_TIMEOUT:  timeout_q    <= cfg_data;
					default: ;
				endcase
			end

			if ((accept && !query_go) || div_done) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE:  if (query_go) state_q <= ST_START;
				ST_START: state_q <= ST_DIV;
				ST_DIV:   if (div_done) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// result word and divider operands
	always_ff @(posedge clk) begin
		if ((accept && !query_go) || div_done) begin
			out_event_q  <= event_d;
			out_total_q  <= total_d;
			out_nodrip_q <= nodrip_d;
			out_rate_q   <= div_done ? div_quot : '0;
		end
		if (query_go) begin
			product_s1 <= NUM_W'(win_drips_q) * NUM_W'(RATE_SCALE);
			divisor_q  <= win_ms_q;
		end
	end

	dcfr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product_s1),
		.divisor  (divisor_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'd0, out_rate_q, out_nodrip_q, out_total_q, out_event_q};

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside a query");

	a_busy_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !out_vld_q)
		else $error("result word pending during a query");

	a_event_no_rate: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[65:34] == '0)
		else $error("drip event word carries a flow rate");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> divisor_q != '0)
		else $error("divider started with zero elapsed time");

endmodule
